[rtl/fftp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feature fold token position package
// Shared widths, constants and request/result types for the feature folding
// block.
// ----------------------------------------------------------------------------
package fftp_pkg;

  localparam int unsigned FeatW       = 18;
  localparam int unsigned FracW       = 16;
  localparam int unsigned QW          = 8;
  localparam int unsigned TermW       = 32;
  localparam int unsigned SumW        = 43;
  localparam int unsigned MagW        = SumW - 1;
  localparam int unsigned VocabW      = 24;
  localparam int unsigned BlockW      = 16;
  localparam int unsigned CallW       = 32;
  localparam int unsigned MaxFeatures = 1024;
  localparam int unsigned IdxW        = $clog2(MaxFeatures + 1);
  localparam int unsigned DivSteps    = MagW;
  localparam int unsigned CntW        = $clog2(DivSteps);
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CfgDataW    = VocabW;

  localparam logic [TermW-1:0] FoldMult = 32'd1315423911;
  localparam logic [FracW:0]   FeatOne  = 17'd65536;

  localparam logic [CfgIdxW-1:0] CfgVocabSize = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgBlockSize = 1'b1;

  typedef struct packed {
    logic signed [FeatW-1:0] feature;
    logic                    last_feature;
    logic                    empty_vector;
  } in_req_t;

  typedef struct packed {
    logic [VocabW-1:0] token_id;
    logic [BlockW-1:0] position;
    logic              too_long;
  } out_rsp_t;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StMul  = 6'b000010,
    StAcc  = 6'b000100,
    StPrep = 6'b001000,
    StDiv  = 6'b010000,
    StFin  = 6'b100000
  } state_e;

endpackage

[rtl/feature_fold_token_position.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feature fold token position
// Folds a stream of Q1.16 features into a token id and a position id.
// ----------------------------------------------------------------------------
// A non-final feature passes through accept, 8 bit-serial multiply steps
// through the shift-and-add unit, and one accumulate step.
// A final request adds magnitude setup, 42 restoring division steps that
// produce both remainders, and a result load that waits for a free output.
// One request is in work at a time; a stalled result holds up the next result.
// Reset clears the accumulator, feature index, call counter and both moduli.
module feature_fold_token_position
  import fftp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_req_t             in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_rsp_t            out_rsp_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [VocabW-1:0] vocab_q;
  logic [BlockW-1:0] block_q;
  logic [SumW-1:0]   fold_sum_q;
  logic [IdxW-1:0]   index_q;
  logic [CallW-1:0]  call_q;
  logic              overflow_q;
  logic [CntW-1:0]   cnt_q;
  logic              out_valid_q;

  logic [QW-1:0]     q_q;
  logic [TermW-1:0]  mcand_q;
  logic [TermW-1:0]  acc_q;
  logic              last_q;
  logic [MagW-1:0]   dvd_tok_q;
  logic [MagW-1:0]   dvd_pos_q;
  logic [VocabW-1:0] rem_tok_q;
  logic [BlockW-1:0] rem_pos_q;
  out_rsp_t          out_rsp_q;

  logic              accept;
  logic              fold;
  logic              room;
  logic [FracW:0]    feat_clamp;
  logic [VocabW:0]   feat_x256;
  logic [QW-1:0]     q_new;
  logic [TermW-1:0]  term;
  logic [SumW-1:0]   sum_neg;
  logic [MagW-1:0]   mag;
  logic [VocabW+1:0] tok_diff;
  logic [BlockW+1:0] pos_diff;
  logic              out_free;
  logic              mul_done;
  logic              div_done;

  assign accept   = in_valid_i && (state_q == StIdle);
  assign fold     = !(in_req_i.last_feature && in_req_i.empty_vector);
  assign room     = index_q < IdxW'(MaxFeatures);
  assign out_free = !out_valid_q || !out_stall_i;
  assign mul_done = cnt_q == CntW'(QW - 1);
  assign div_done = cnt_q == CntW'(DivSteps - 1);

  always_comb begin
    if (in_req_i.feature[FeatW-1]) begin
      feat_clamp = '0;
    end else if (in_req_i.feature[FracW:0] > FeatOne) begin
      feat_clamp = FeatOne;
    end else begin
      feat_clamp = in_req_i.feature[FracW:0];
    end
  end

  // Scaling by 255 is a shift by eight minus the value, plus the rounding half.
  assign feat_x256 = {feat_clamp, 8'd0};
  assign q_new     = QW'((feat_x256 - (VocabW+1)'(feat_clamp)
                          + (VocabW+1)'(32768)) >> FracW);

  assign term    = acc_q ^ TermW'(index_q);
  assign sum_neg = '0 - fold_sum_q;
  assign mag     = fold_sum_q[SumW-1] ? sum_neg[MagW-1:0] : fold_sum_q[MagW-1:0];

  assign tok_diff = {1'b0, rem_tok_q, dvd_tok_q[MagW-1]} - {2'b00, vocab_q};
  assign pos_diff = {1'b0, rem_pos_q, dvd_pos_q[MagW-1]} - {2'b00, block_q};

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (accept) begin
          if (fold && room) begin
            state_d = StMul;
          end else if (in_req_i.last_feature) begin
            state_d = StPrep;
          end
        end
      end
      StMul: begin
        if (mul_done) begin
          state_d = StAcc;
        end
      end
      StAcc: begin
        state_d = last_q ? StPrep : StIdle;
      end
      StPrep: begin
        state_d = StDiv;
      end
      StDiv: begin
        if (div_done) begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      vocab_q     <= '0;
      block_q     <= '0;
      fold_sum_q  <= '0;
      index_q     <= '0;
      call_q      <= '0;
      overflow_q  <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgVocabSize: vocab_q <= cfg_data_i[VocabW-1:0];
          CfgBlockSize: block_q <= cfg_data_i[BlockW-1:0];
          default: ;
        endcase
      end
      if (accept && fold && !room) begin
        overflow_q <= 1'b1;
      end
      case (state_q)
        StIdle: cnt_q <= '0;
        StMul:  cnt_q <= mul_done ? '0 : cnt_q + 1'b1;
        StDiv:  cnt_q <= cnt_q + 1'b1;
        default: cnt_q <= '0;
      endcase
      if (state_q == StAcc) begin
        fold_sum_q <= fold_sum_q + {{(SumW-TermW){term[TermW-1]}}, term};
        index_q    <= index_q + 1'b1;
      end
      if ((state_q == StFin) && out_free) begin
        out_valid_q <= 1'b1;
        call_q      <= call_q + 1'b1;
        fold_sum_q  <= '0;
        index_q     <= '0;
        overflow_q  <= 1'b0;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        if (accept) begin
          q_q     <= q_new;
          mcand_q <= FoldMult;
          acc_q   <= '0;
          last_q  <= in_req_i.last_feature;
        end
      end
      StMul: begin
        if (q_q[0]) begin
          acc_q <= acc_q + mcand_q;
        end
        q_q     <= q_q >> 1;
        mcand_q <= mcand_q << 1;
      end
      StPrep: begin
        dvd_tok_q <= mag;
        dvd_pos_q <= MagW'(call_q);
        rem_tok_q <= '0;
        rem_pos_q <= '0;
      end
      StDiv: begin
        dvd_tok_q <= dvd_tok_q << 1;
        dvd_pos_q <= dvd_pos_q << 1;
        rem_tok_q <= tok_diff[VocabW+1] ? {rem_tok_q[VocabW-2:0], dvd_tok_q[MagW-1]}
                                        : tok_diff[VocabW-1:0];
        rem_pos_q <= pos_diff[BlockW+1] ? {rem_pos_q[BlockW-2:0], dvd_pos_q[MagW-1]}
                                        : pos_diff[BlockW-1:0];
      end
      StFin: begin
        if (out_free) begin
          out_rsp_q.token_id <= (vocab_q == '0) ? '0 : rem_tok_q;
          out_rsp_q.position <= (block_q == '0) ? '0 : rem_pos_q;
          out_rsp_q.too_long <= overflow_q;
        end
      end
      default: ;
    endcase
  end

  assign in_stall_o  = state_q != StIdle;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // The multiplier only runs on a feature that still has room in the vector.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMul) |-> (index_q < IdxW'(MaxFeatures)))
    else $error("multiply started beyond the feature limit");

  // A new result is only raised from the final state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == StFin))
    else $error("result raised outside the final state");

  // A pending stalled result holds the finished request in the final state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFin && out_valid_q && out_stall_i) |=> (state_q == StFin))
    else $error("result overwritten while stalled");

  // The division step counter never reaches DivSteps.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDiv) |-> (cnt_q < CntW'(DivSteps)))
    else $error("division step count out of range");

  // A finished request always clears the fold state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFin && out_free) |=> (index_q == '0 && fold_sum_q == '0))
    else $error("fold state not cleared after a result");

endmodule

[test/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Feature fold token position testbench
// Streams feature vectors into the block and checks every token id, position
// and too-long flag against a predictor kept inside the bench. Covers
// clamping and rounding, empty vectors, zero and extreme moduli, and vectors
// longer than the feature limit. The input idles and the output stalls at random.
// ----------------------------------------------------------------------------
module tb;
  import fftp_pkg::*;

  localparam int unsigned SettleCycles = 64;
  localparam int unsigned QuietLimit   = 5000;
  localparam int unsigned IdlePercent  = 35;
  localparam int unsigned PhaseItems   = 10;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  in_req_t             in_req    = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  out_rsp_t            out_rsp;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx   = CfgVocabSize;
  logic [CfgDataW-1:0] cfg_data  = '0;

  bit                  steady       = 1'b0;
  int unsigned         errors       = 0;
  int unsigned         quiet_cycles = 0;

  longint              fold_acc   = 0;
  int unsigned         feat_count = 0;
  logic [CallW-1:0]    calls      = '0;
  logic                overflow   = 1'b0;
  logic [VocabW-1:0]   vocab_mod  = '0;
  logic [BlockW-1:0]   block_mod  = '0;
  out_rsp_t            pending_tokens[$];

  feature_fold_token_position uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= steady ? 1'b0 : ($urandom_range(99) < IdlePercent);
  end

  function automatic logic [QW-1:0] quantize(input logic signed [FeatW-1:0] feature);
    int          level;
    int unsigned scaled;
    level = int'(feature);
    if (level < 0) begin
      level = 0;
    end else if (level > int'(FeatOne)) begin
      level = int'(FeatOne);
    end
    scaled = unsigned'(level * 255 + 32768);
    return QW'(scaled >> FracW);
  endfunction

  task automatic predict_token(input in_req_t req);
    logic [TermW-1:0]        term;
    logic signed [TermW-1:0] sterm;
    longint                  mag;
    out_rsp_t                rsp;
    if (!(req.last_feature && req.empty_vector)) begin
      if (feat_count >= MaxFeatures) begin
        overflow = 1'b1;
      end else begin
        term = {{(TermW-QW){1'b0}}, quantize(req.feature)} * FoldMult;
        term = term ^ TermW'(feat_count);
        sterm = $signed(term);
        fold_acc += sterm;
        feat_count++;
      end
    end
    if (req.last_feature) begin
      mag = (fold_acc < 0) ? -fold_acc : fold_acc;
      rsp.token_id = (vocab_mod == '0) ? '0 : VocabW'(mag % longint'(vocab_mod));
      rsp.position = (block_mod == '0) ? '0 : BlockW'(calls % block_mod);
      rsp.too_long = overflow;
      pending_tokens.push_back(rsp);
      calls++;
      fold_acc = 0;
      feat_count = 0;
      overflow = 1'b0;
    end
  endtask

  task automatic compare_field(input string field, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_tokens.size() == 0) begin
        $display("%0t: unexpected result, expected none actual %p", $time, out_rsp);
        errors++;
      end else begin
        compare_field("token_id", longint'(pending_tokens[0].token_id),
                      longint'(out_rsp.token_id));
        compare_field("position", longint'(pending_tokens[0].position),
                      longint'(out_rsp.position));
        compare_field("too_long", longint'(pending_tokens[0].too_long),
                      longint'(out_rsp.too_long));
        void'(pending_tokens.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  function automatic in_req_t make_req(input int feature,
                                       input logic last, input logic empty);
    in_req_t req;
    req.feature      = FeatW'(feature);
    req.last_feature = last;
    req.empty_vector = empty;
    return req;
  endfunction

  function automatic logic signed [FeatW-1:0] rand_feature();
    case ($urandom_range(9))
      0: return '0;
      1: return FeatW'(FeatOne);
      2: return FeatW'($urandom);
      3: return -FeatW'($urandom_range(1, 131072));
      4: return FeatW'($urandom_range(65537, 131071));
      default: return FeatW'($urandom_range(0, 65536));
    endcase
  endfunction

  task automatic send_request(input in_req_t req);
    while (!steady && $urandom_range(99) < IdlePercent) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_token(req);
  endtask

  task automatic send_vector(input int unsigned len, input logic close_empty);
    for (int unsigned i = 0; i < len; i++) begin
      send_request(make_req(int'(rand_feature()), 1'b0, 1'($urandom_range(1))));
    end
    send_request(make_req(int'(rand_feature()), 1'b1, close_empty));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_moduli(input logic [VocabW-1:0] vocab, input logic [BlockW-1:0] block);
    cfg_we   <= 1'b1;
    cfg_idx  <= CfgVocabSize;
    cfg_data <= vocab;
    @(posedge clk);
    vocab_mod = vocab;
    cfg_idx  <= CfgBlockSize;
    cfg_data <= CfgDataW'(block);
    @(posedge clk);
    block_mod = block;
    cfg_we   <= 1'b0;
  endtask

  task automatic test_directed;
    set_moduli('1, '1);
    send_request(make_req(-131072, 1'b1, 1'b0));
    send_request(make_req(-1, 1'b1, 1'b0));
    send_request(make_req(0, 1'b1, 1'b0));
    send_request(make_req(1, 1'b1, 1'b0));
    send_request(make_req(128, 1'b1, 1'b0));
    send_request(make_req(129, 1'b1, 1'b0));
    send_request(make_req(32767, 1'b1, 1'b0));
    send_request(make_req(65535, 1'b1, 1'b0));
    send_request(make_req(65536, 1'b1, 1'b0));
    send_request(make_req(65537, 1'b1, 1'b0));
    send_request(make_req(131071, 1'b1, 1'b0));
    send_request(make_req(-1, 1'b1, 1'b1));
    send_request(make_req(65536, 1'b0, 1'b1));
    send_request(make_req(40000, 1'b0, 1'b1));
    send_request(make_req(65536, 1'b1, 1'b0));
    send_request(make_req(50000, 1'b0, 1'b0));
    send_request(make_req(-5, 1'b0, 1'b0));
    send_request(make_req(65536, 1'b1, 1'b1));
    for (int i = 0; i < 4; i++) begin
      send_request(make_req(65536, 1'(i == 3), 1'b0));
    end
    drain;
  endtask

  task automatic test_moduli_sweep;
    int unsigned sent;
    int unsigned len;
    for (int phase = 0; phase < 7; phase++) begin
      case (phase)
        0: set_moduli('0, '0);
        1: set_moduli(VocabW'(1), BlockW'(1));
        2: set_moduli('1, '1);
        3: set_moduli(VocabW'($urandom_range(1, 1000)), BlockW'($urandom_range(1, 300)));
        4: set_moduli(VocabW'($urandom), BlockW'($urandom));
        5: set_moduli('0, BlockW'($urandom_range(1, 65535)));
        default: set_moduli(VocabW'($urandom_range(1, 16777215)), '0);
      endcase
      steady = (phase == 4);
      sent = 0;
      while (sent < PhaseItems) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 6);
        send_vector(len, 1'($urandom_range(7) == 0));
        sent += len + 1;
      end
      drain;
      steady = 1'b0;
    end
  endtask

  task automatic test_overlong;
    set_moduli(VocabW'($urandom_range(1, 16777215)), BlockW'($urandom_range(1, 65535)));
    send_vector(MaxFeatures, 1'b0);
    send_vector(2, 1'b0);
    drain;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed;
    test_moduli_sweep;
    test_overlong;
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
